### rtl/kufm_pkg.sv
`timescale 1ns / 1ps
package kufm_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int SIZE_W       = VIDX_W + 1;
  localparam int WEIGHT_W     = 32;
  localparam int SUM_W        = 48;
  localparam int VCOUNT_W     = 11;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef struct packed {
    logic [VIDX_W-1:0] parent;
    logic [SIZE_W-1:0] size;
  } node_t;
endpackage

### rtl/kufm_if.sv
`timescale 1ns / 1ps
interface kufm_in_if import kufm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [VIDX_W-1:0]          vertex_a;
  logic [VIDX_W-1:0]          vertex_b;
  logic signed [WEIGHT_W-1:0] weight;
  modport source (output valid, operation, vertex_a, vertex_b, weight, input ready);
  modport sink   (input valid, operation, vertex_a, vertex_b, weight, output ready);
endinterface

interface kufm_out_if import kufm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    merged;
  logic signed [SUM_W-1:0] total_weight;
  logic [1:0]              status;
  modport source (output valid, merged, total_weight, status, input ready);
  modport sink   (input valid, merged, total_weight, status, output ready);
endinterface

interface kufm_cfg_if import kufm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VCOUNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/kruskal_union_find_mst_unit.sv
`timescale 1ns / 1ps
// Kruskal MST engine over a union-find forest (union by size, full path
// compression) held in one single-port RAM of MAX_VERTICES entries with a
// registered read. An edge item reads every node on each root find (root
// included), closes each find, rewrites the parent of every node on the
// path to point at its root, makes two union writes when the trees differ
// and then posts the result. A rejected edge goes from acceptance straight
// to the done state, which then sets the output valid. A clear item, and the
// clearing pass after reset, sweep the RAM one entry a cycle; no item is
// taken during the pass. One item is processed at a time and its result is
// held in an output register; the next item is taken once that result has
// been accepted.
module kruskal_union_find_mst_unit import kufm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kufm_in_if.sink     in_i,
  kufm_out_if.source  out_o,
  kufm_cfg_if.sink    cfg_i
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CLEAR   = 9'b000000010,
    S_FIND_RQ = 9'b000000100,
    S_FIND_WT = 9'b000001000,
    S_CMP_RQ  = 9'b000010000,
    S_CMP_WT  = 9'b000100000,
    S_UNION1  = 9'b001000000,
    S_UNION2  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e                     state_q, state_d;
  logic [VCOUNT_W-1:0]        vcount_q;
  logic [VIDX_W-1:0]          cnt_q, cnt_d;
  logic                       report_q, report_d;
  logic [VIDX_W-1:0]          x_q, x_d, r_q, r_d, vb_q, vb_d, ra_q, ra_d;
  logic [SIZE_W-1:0]          rsz_q, rsz_d, sa_q, sa_d;
  logic                       side_q, side_d;
  logic signed [WEIGHT_W-1:0] w_q, w_d, prev_q, prev_d;
  logic                       seen_q, seen_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic                       ovalid_q, ovalid_d, merged_q, merged_d;
  logic [1:0]                 status_q, status_d;

  node_t             mem_q [MAX_VERTICES];
  node_t             rdata_q, mem_wdata;
  logic              mem_we, mem_re;
  logic [VIDX_W-1:0] mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = (state_q == S_IDLE) && !ovalid_q;
  assign out_o.valid  = ovalid_q;
  assign out_o.merged = merged_q;
  assign out_o.total_weight = sum_q;
  assign out_o.status = status_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; report_d = report_q;
    x_d = x_q; r_d = r_q; vb_d = vb_q; ra_d = ra_q;
    rsz_d = rsz_q; sa_d = sa_q; side_d = side_q; w_d = w_q;
    prev_d = prev_q; seen_d = seen_q; sum_d = sum_q;
    ovalid_d = ovalid_q; merged_d = merged_q; status_d = status_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = r_q;
    mem_wdata = '{parent: r_q, size: rsz_q};

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && !ovalid_q) begin
          vb_d = in_i.vertex_b; w_d = in_i.weight;
          merged_d = 1'b0; status_d = STATUS_OK;
          if (in_i.operation == OP_CLEAR) begin
            cnt_d = '0; report_d = 1'b1; state_d = S_CLEAR;
          end else if ({1'b0, in_i.vertex_a} >= vcount_q ||
                       {1'b0, in_i.vertex_b} >= vcount_q) begin
            status_d = STATUS_RANGE; state_d = S_DONE;
          end else if (seen_q && in_i.weight < prev_q) begin
            status_d = STATUS_ORDER; state_d = S_DONE;
          end else begin
            x_d = in_i.vertex_a; r_d = in_i.vertex_a; side_d = 1'b0;
            state_d = S_FIND_RQ;
          end
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1; mem_addr = cnt_q;
        mem_wdata = '{parent: cnt_q, size: SIZE_W'(1)};
        cnt_d = cnt_q + VIDX_W'(1);
        if (cnt_q == VIDX_W'(MAX_VERTICES - 1)) begin
          sum_d = '0; prev_d = '0; seen_d = 1'b0;
          state_d = report_q ? S_DONE : S_IDLE;
        end
      end
      S_FIND_RQ: begin
        mem_re = 1'b1; mem_addr = r_q; state_d = S_FIND_WT;
      end
      S_FIND_WT: begin
        if (rdata_q.parent == r_q) begin
          rsz_d = rdata_q.size; state_d = S_CMP_RQ;
        end else begin
          r_d = rdata_q.parent; state_d = S_FIND_RQ;
        end
      end
      S_CMP_RQ: begin
        if (x_q == r_q) begin
          if (!side_q) begin
            ra_d = r_q; sa_d = rsz_q; side_d = 1'b1;
            x_d = vb_q; r_d = vb_q; state_d = S_FIND_RQ;
          end else begin
            prev_d = w_q; seen_d = 1'b1;
            if (ra_q == r_q) begin
              state_d = S_DONE;
            end else begin
              merged_d = 1'b1;
              sum_d = sum_q + SUM_W'(w_q);
              state_d = S_UNION1;
            end
          end
        end else begin
          mem_re = 1'b1; mem_addr = x_q; state_d = S_CMP_WT;
        end
      end
      S_CMP_WT: begin
        // point x straight at the root, then follow its old parent
        mem_we = 1'b1; mem_addr = x_q;
        mem_wdata = '{parent: r_q, size: rdata_q.size};
        x_d = rdata_q.parent; state_d = S_CMP_RQ;
      end
      S_UNION1: begin
        mem_we = 1'b1;
        if (sa_q <= rsz_q) begin
          mem_addr = ra_q; mem_wdata = '{parent: r_q, size: sa_q};
        end else begin
          mem_addr = r_q; mem_wdata = '{parent: ra_q, size: rsz_q};
        end
        state_d = S_UNION2;
      end
      S_UNION2: begin
        mem_we = 1'b1;
        mem_addr = (sa_q <= rsz_q) ? r_q : ra_q;
        mem_wdata = '{parent: mem_addr, size: sa_q + rsz_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      report_q <= 1'b0;
      vcount_q <= VCOUNT_W'(1024);
      seen_q   <= 1'b0;
      prev_q   <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
      side_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      seen_q   <= seen_d;
      prev_q   <= prev_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
      side_q   <= side_d;
      if (cfg_i.valid) begin
        vcount_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; vb_q <= vb_d; ra_q <= ra_d;
    rsz_q <= rsz_d; sa_q <= sa_d; w_q <= w_d;
    merged_q <= merged_d; status_q <= status_d;
  end

endmodule
